FILE: src/lzrw_pkg.sv
// Shared types and constants of the LZSS ring window decoder.
`timescale 1ns / 1ps

package lzrw_pkg;

	// History window
	localparam int WIN_SIZE = 4096;
	localparam int WIN_AW = $clog2(WIN_SIZE);
	localparam int FILL_W = WIN_AW + 1;
	localparam logic [WIN_AW-1:0] POS_START = WIN_AW'(12'hFEE);

	// Output count and expected length
	localparam int COUNT_W = 24;
	localparam int LEN_W = 24;
	localparam int CMP_W = (COUNT_W > LEN_W) ? COUNT_W : LEN_W;

	// Match length field: low nibble plus three, so 3 to 18
	localparam int MLEN_W = 5;
	localparam logic [MLEN_W-1:0] MATCH_MIN = MLEN_W'(3);

	// Token phases
	localparam logic [1:0] PH_SHIFT = 2'd0;
	localparam logic [1:0] PH_FRESH = 2'd1;
	localparam logic [1:0] PH_MATCH2 = 2'd2;

	// Command queue and output queue depths
	localparam int Q_DEPTH = 2;
	localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QC_W = $clog2(Q_DEPTH + 1);
	localparam int OUT_DEPTH = 2;
	localparam int OP_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
	localparam int OC_W = $clog2(OUT_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_LIT,
		CMD_MATCH,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic restart;
		logic [7:0] data;
		logic [WIN_AW-1:0] src;
		logic [MLEN_W-1:0] len;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_COPY
	} bk_state_t;

endpackage

FILE: src/lzrw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lzrw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, and read the old contents on a collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/lzrw_front.sv
// Front end: accepts compressed bytes, tracks flags and count, emits commands.
`timescale 1ns / 1ps

module lzrw_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lzrw_pkg::LEN_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  data_byte,
	input  logic                        start_stream,
	output logic                        push_valid,
	input  logic                        push_ready,
	output lzrw_pkg::cmd_t              push_cmd
);

	logic [lzrw_pkg::LEN_W-1:0]   exp_len_q;
	logic [8:0]                   flags_q;
	logic [1:0]                   phase_q;
	logic [7:0]                   plow_q;
	logic [lzrw_pkg::COUNT_W-1:0] count_q;
	logic                         ended_q;

	logic [8:0]                   n_flags;
	logic [1:0]                   n_phase;
	logic [7:0]                   n_plow;
	logic [lzrw_pkg::COUNT_W-1:0] n_count;
	logic                         n_ended;
	lzrw_pkg::cmd_kind_t          kind;
	logic [lzrw_pkg::MLEN_W-1:0]  mlen;
	logic [lzrw_pkg::COUNT_W:0]   sum;
	logic [lzrw_pkg::COUNT_W-1:0] sat_count;
	logic                         accept;

	assign in_ready = push_ready;
	assign accept = in_valid & in_ready;

	// Match length from the low nibble
	assign mlen = lzrw_pkg::MLEN_W'(data_byte[3:0]) + lzrw_pkg::MATCH_MIN;

	// Classify the beat against the flag and phase state
	always_comb begin
		logic [8:0]                   f_flags;
		logic [1:0]                   f_phase;
		logic [7:0]                   f_plow;
		logic [lzrw_pkg::COUNT_W-1:0] f_count;
		logic                         f_ended;
		logic [8:0]                   shifted;
		logic [8:0]                   tok_flags;
		logic                         reached;
		logic                         fetch;
		f_flags = start_stream ? 9'd0 : flags_q;
		f_phase = start_stream ? lzrw_pkg::PH_SHIFT : phase_q;
		f_plow = start_stream ? 8'd0 : plow_q;
		f_count = start_stream ? '0 : count_q;
		f_ended = start_stream ? 1'b0 : ended_q;
		reached = lzrw_pkg::CMP_W'(f_count) >= lzrw_pkg::CMP_W'(exp_len_q);
		shifted = {1'b0, f_flags[8:1]};
		tok_flags = f_flags;
		fetch = 1'b0;
		n_flags = f_flags;
		n_phase = f_phase;
		n_plow = f_plow;
		n_ended = f_ended;
		kind = lzrw_pkg::CMD_NONE;
		sum = {1'b0, f_count};
		if (f_ended) begin
			kind = lzrw_pkg::CMD_END;
		end else if (f_phase == lzrw_pkg::PH_MATCH2) begin
			kind = lzrw_pkg::CMD_MATCH;
			sum = {1'b0, f_count} + (lzrw_pkg::COUNT_W+1)'(mlen);
			n_phase = lzrw_pkg::PH_SHIFT;
		end else begin
			if (f_phase != lzrw_pkg::PH_FRESH) begin
				if (shifted <= 9'd1) begin
					fetch = 1'b1;
					if (reached) begin
						kind = lzrw_pkg::CMD_END;
						n_ended = 1'b1;
					end else begin
						n_flags = {1'b1, data_byte};
						n_phase = lzrw_pkg::PH_FRESH;
					end
				end else begin
					n_flags = shifted;
					tok_flags = shifted;
				end
			end
			if (!fetch) begin
				if (tok_flags[0]) begin
					if (reached) begin
						kind = lzrw_pkg::CMD_END;
						n_ended = 1'b1;
					end else begin
						kind = lzrw_pkg::CMD_LIT;
						sum = {1'b0, f_count} + (lzrw_pkg::COUNT_W+1)'(1);
						n_phase = lzrw_pkg::PH_SHIFT;
					end
				end else begin
					n_plow = data_byte;
					n_phase = lzrw_pkg::PH_MATCH2;
				end
			end
		end
	end

	// Saturate the count at all ones
	assign sat_count = sum[lzrw_pkg::COUNT_W] ? '1 : sum[lzrw_pkg::COUNT_W-1:0];
	assign n_count = sat_count;

	// Build the command for the back end
	assign push_valid = accept & ((kind != lzrw_pkg::CMD_NONE) | start_stream);
	assign push_cmd.kind = kind;
	assign push_cmd.restart = start_stream;
	assign push_cmd.data = data_byte;
	assign push_cmd.src = {data_byte[7:4], plow_q};
	assign push_cmd.len = mlen;

	// Hold the expected length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= '0;
		end else if (cfg_we) begin
			exp_len_q <= cfg_wdata;
		end
	end

	// Advance the decode state on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= 9'd0;
			phase_q <= lzrw_pkg::PH_SHIFT;
			plow_q <= 8'd0;
			count_q <= '0;
			ended_q <= 1'b0;
		end else if (accept) begin
			flags_q <= n_flags;
			phase_q <= n_phase;
			plow_q <= n_plow;
			count_q <= n_count;
			ended_q <= n_ended;
		end
	end

endmodule

FILE: src/lzrw_cmd_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module lzrw_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  lzrw_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop,
	output lzrw_pkg::cmd_t pop_cmd
);

	lzrw_pkg::cmd_t            entry_q [lzrw_pkg::Q_DEPTH];
	logic [lzrw_pkg::QP_W-1:0] wptr_q;
	logic [lzrw_pkg::QP_W-1:0] rptr_q;
	logic [lzrw_pkg::QC_W-1:0] cnt_q;
	logic                      do_push;
	logic                      do_pop;

	assign push_ready = cnt_q != lzrw_pkg::QC_W'(lzrw_pkg::Q_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_cmd = entry_q[rptr_q];
	assign do_push = push_valid & push_ready;
	assign do_pop = pop & pop_valid;

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == lzrw_pkg::QP_W'(lzrw_pkg::Q_DEPTH - 1)) ? '0
					: wptr_q + lzrw_pkg::QP_W'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == lzrw_pkg::QP_W'(lzrw_pkg::Q_DEPTH - 1)) ? '0
					: rptr_q + lzrw_pkg::QP_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + lzrw_pkg::QC_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - lzrw_pkg::QC_W'(1);
			end
		end
	end

endmodule

FILE: src/lzrw_back.sv
// Back end: runs commands against the history ring and queues output beats.
`timescale 1ns / 1ps

module lzrw_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  lzrw_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           last_of_run,
	output logic           ended
);

	lzrw_pkg::bk_state_t state_q, state_d;

	logic [lzrw_pkg::WIN_AW-1:0] cur_src_q;
	logic [lzrw_pkg::MLEN_W-1:0] cur_rem_q;
	logic [lzrw_pkg::WIN_AW-1:0] wp_q;
	logic [lzrw_pkg::FILL_W-1:0] fill_q;

	// Issue stage outputs
	logic                        issue;
	logic                        iss_end;
	logic                        iss_lit;
	logic                        iss_last;
	logic [lzrw_pkg::WIN_AW-1:0] iss_addr;
	logic                        load_match;
	logic                        do_restart;
	logic                        can_issue;
	logic [lzrw_pkg::WIN_AW-1:0] iss_off;
	logic                        iss_hit;
	logic                        iss_byp;

	// Data stage
	logic                        valid_s2;
	logic                        end_s2;
	logic                        lit_s2;
	logic                        last_s2;
	logic                        byp_s2;
	logic                        hit_s2;
	logic [7:0]                  lit_data_s2;
	logic [7:0]                  byp_data_s2;
	logic [lzrw_pkg::WIN_AW-1:0] waddr_s2;
	logic [7:0]                  rdata;
	logic [7:0]                  byte_s2;
	logic                        ram_we;

	// Output queue
	logic [7:0]                ob_data_q [lzrw_pkg::OUT_DEPTH];
	logic                      ob_last_q [lzrw_pkg::OUT_DEPTH];
	logic                      ob_end_q [lzrw_pkg::OUT_DEPTH];
	logic [lzrw_pkg::OP_W-1:0] ob_wptr_q;
	logic [lzrw_pkg::OP_W-1:0] ob_rptr_q;
	logic [lzrw_pkg::OC_W-1:0] ob_cnt_q;
	logic                      ob_pop;

	// Credit check: queued beats plus the one in the data stage
	assign ob_pop = out_valid & out_ready;
	assign can_issue = ((lzrw_pkg::OC_W+1)'(ob_cnt_q) + (lzrw_pkg::OC_W+1)'(valid_s2)
		< (lzrw_pkg::OC_W+1)'(lzrw_pkg::OUT_DEPTH)) | ob_pop;

	// Sequencer outputs
	always_comb begin
		issue = 1'b0;
		iss_end = 1'b0;
		iss_lit = 1'b0;
		iss_last = 1'b0;
		iss_addr = cur_src_q;
		load_match = 1'b0;
		cmd_pop = 1'b0;
		do_restart = 1'b0;
		case (state_q)
			lzrw_pkg::BK_IDLE: begin
				if (cmd_valid && !(cmd.restart && valid_s2)) begin
					case (cmd.kind)
						lzrw_pkg::CMD_NONE: begin
							cmd_pop = 1'b1;
						end
						lzrw_pkg::CMD_LIT, lzrw_pkg::CMD_END: begin
							if (can_issue) begin
								cmd_pop = 1'b1;
								issue = 1'b1;
								iss_end = cmd.kind == lzrw_pkg::CMD_END;
								iss_lit = cmd.kind == lzrw_pkg::CMD_LIT;
								iss_last = 1'b1;
							end
						end
						lzrw_pkg::CMD_MATCH: begin
							if (can_issue) begin
								cmd_pop = 1'b1;
								issue = 1'b1;
								iss_addr = cmd.src;
								load_match = 1'b1;
							end
						end
						default: begin
						end
					endcase
					do_restart = cmd_pop & cmd.restart;
				end
			end
			lzrw_pkg::BK_COPY: begin
				if (can_issue) begin
					issue = 1'b1;
					iss_last = cur_rem_q == lzrw_pkg::MLEN_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lzrw_pkg::BK_IDLE: begin
				if (load_match) begin
					state_d = lzrw_pkg::BK_COPY;
				end
			end
			lzrw_pkg::BK_COPY: begin
				if (issue && iss_last) begin
					state_d = lzrw_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = lzrw_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzrw_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance the copy source and remaining length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_src_q <= '0;
			cur_rem_q <= '0;
		end else if (load_match) begin
			cur_src_q <= cmd.src + lzrw_pkg::WIN_AW'(1);
			cur_rem_q <= cmd.len - lzrw_pkg::MLEN_W'(1);
		end else if (issue && state_q == lzrw_pkg::BK_COPY) begin
			cur_src_q <= cur_src_q + lzrw_pkg::WIN_AW'(1);
			cur_rem_q <= cur_rem_q - lzrw_pkg::MLEN_W'(1);
		end
	end

	// Entries behind the write position written since restart hold data; others read zero
	assign iss_off = iss_addr - lzrw_pkg::POS_START;
	assign iss_hit = {1'b0, iss_off} < fill_q;
	// Forward a byte being written this cycle to a read of the same entry
	assign iss_byp = valid_s2 & ~end_s2 & (iss_addr == waddr_s2);

	// Write position and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= lzrw_pkg::POS_START;
			fill_q <= '0;
		end else begin
			if (do_restart) begin
				wp_q <= lzrw_pkg::POS_START;
			end else if (issue && !iss_end) begin
				wp_q <= wp_q + lzrw_pkg::WIN_AW'(1);
			end
			if (do_restart) begin
				fill_q <= '0;
			end else if (ram_we && fill_q != lzrw_pkg::FILL_W'(lzrw_pkg::WIN_SIZE)) begin
				fill_q <= fill_q + lzrw_pkg::FILL_W'(1);
			end
		end
	end

	// Data stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= issue;
		end
	end

	// Data stage payload
	always_ff @(posedge clk) begin
		if (issue) begin
			end_s2 <= iss_end;
			lit_s2 <= iss_lit;
			last_s2 <= iss_last;
			byp_s2 <= iss_byp;
			hit_s2 <= iss_hit;
			lit_data_s2 <= cmd.data;
			byp_data_s2 <= byte_s2;
			waddr_s2 <= wp_q;
		end
	end

	lzrw_ram #(
		.WIDTH(8),
		.DEPTH(lzrw_pkg::WIN_SIZE)
	) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr_s2),
		.wdata(byte_s2),
		.raddr(iss_addr),
		.rdata(rdata)
	);

	// Pick the byte of the data stage
	always_comb begin
		if (end_s2) begin
			byte_s2 = 8'd0;
		end else if (lit_s2) begin
			byte_s2 = lit_data_s2;
		end else if (byp_s2) begin
			byte_s2 = byp_data_s2;
		end else if (hit_s2) begin
			byte_s2 = rdata;
		end else begin
			byte_s2 = 8'd0;
		end
	end

	assign ram_we = valid_s2 & ~end_s2;

	// Output queue storage
	always_ff @(posedge clk) begin
		if (valid_s2) begin
			ob_data_q[ob_wptr_q] <= byte_s2;
			ob_last_q[ob_wptr_q] <= last_s2;
			ob_end_q[ob_wptr_q] <= end_s2;
		end
	end

	// Output queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wptr_q <= '0;
			ob_rptr_q <= '0;
			ob_cnt_q <= '0;
		end else begin
			if (valid_s2) begin
				ob_wptr_q <= (ob_wptr_q == lzrw_pkg::OP_W'(lzrw_pkg::OUT_DEPTH - 1)) ? '0
					: ob_wptr_q + lzrw_pkg::OP_W'(1);
			end
			if (ob_pop) begin
				ob_rptr_q <= (ob_rptr_q == lzrw_pkg::OP_W'(lzrw_pkg::OUT_DEPTH - 1)) ? '0
					: ob_rptr_q + lzrw_pkg::OP_W'(1);
			end
			if (valid_s2 && !ob_pop) begin
				ob_cnt_q <= ob_cnt_q + lzrw_pkg::OC_W'(1);
			end else if (ob_pop && !valid_s2) begin
				ob_cnt_q <= ob_cnt_q - lzrw_pkg::OC_W'(1);
			end
		end
	end

	assign out_valid = ob_cnt_q != '0;
	assign out_byte = ob_data_q[ob_rptr_q];
	assign last_of_run = ob_last_q[ob_rptr_q];
	assign ended = ob_end_q[ob_rptr_q];

`ifndef NO_ASSERTIONS
	a_ob_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s2 && ob_cnt_q == lzrw_pkg::OC_W'(lzrw_pkg::OUT_DEPTH) && !ob_pop))
		else $error("output queue overflow");

	a_copy_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lzrw_pkg::BK_COPY |-> cur_rem_q != '0)
		else $error("copy running with no bytes left");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= lzrw_pkg::FILL_W'(lzrw_pkg::WIN_SIZE))
		else $error("fill count beyond window");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ended |-> last_of_run && out_byte == 8'd0)
		else $error("status beat not last or not zero");

	a_restart_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		do_restart |-> !valid_s2)
		else $error("restart with a byte in flight");
`endif

endmodule

FILE: src/lzss_ring_window_decoder.sv
// A literal or the first byte of a match passes the command queue, data stage and
// output queue. Throughput: one output beat per cycle while out_ready is high; a match
// keeps the back end busy for its 3 to 18 bytes, read one per cycle from the history
// RAM. Inputs are taken one per cycle while the two-entry command queue has room.
// Reset: arst_n clears control, count and flags; the ring is not swept, a fill count
// makes unwritten entries read as zero, so the block is ready straight after reset.
`timescale 1ns / 1ps

module lzss_ring_window_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lzrw_pkg::LEN_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       start_stream,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [7:0]                 out_byte,
	output logic                       last_of_run,
	output logic                       ended
);

	logic           push_valid;
	logic           push_ready;
	lzrw_pkg::cmd_t push_cmd;
	logic           cmd_valid;
	logic           cmd_pop;
	lzrw_pkg::cmd_t cmd;

	lzrw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.start_stream(start_stream),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_cmd    (push_cmd)
	);

	lzrw_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (cmd_valid),
		.pop       (cmd_pop),
		.pop_cmd   (cmd)
	);

	lzrw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_of_run(last_of_run),
		.ended      (ended)
	);

endmodule
